### design/ucf_pkg.sv
// Shared constants for the universal comb filter: register indexes,
// fixed field widths and default sizes. No dependencies.
package ucf_pkg;

  localparam int DEF_MAX_DELAY    = 4096;
  localparam int DEF_SAMPLE_WIDTH = 16;

  localparam int GAIN_W     = 16;
  localparam int GAIN_FRAC  = 15;
  localparam int DELAY_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FIR_GAIN     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IIR_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 2'd2;

endpackage

### design/ucf_hist_mem.sv
// Delay-line storage: past input and past output samples, one shared
// address per port. One write port, one read port with registered data.
module ucf_hist_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_x,
  input  logic [DW-1:0] wr_y,
  output logic [DW-1:0] rd_x,
  output logic [DW-1:0] rd_y
);

  logic [DW-1:0] mem_x [DEPTH];
  logic [DW-1:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  // read returns the old contents when the same entry is written this edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
    end
  end

endmodule

### design/universal_comb_filter.sv
// Universal comb filter, top level: y = sat(round(x + a*x[n-D] + b*y[n-D])).
// Uses ucf_pkg and ucf_hist_mem.
//
// The block takes no new item while the last one is still in stage 1; that limit is set by the
// loop through the history memory: an item's saturated output is written back on
// the same edge at which the next item reads its delayed samples, and a bypass
// register covers that overlap. Each item passes stage 1, stage 2 and the output
// register, and is held longer only while the output is stalled. Memory entries not
// yet written since reset read as zero by tracking the fill level, so there is no
// clearing pass after reset. Delay 0 acts as 1, a delay above MAX_DELAY acts as MAX_DELAY.
module universal_comb_filter #(
  parameter int MAX_DELAY    = ucf_pkg::DEF_MAX_DELAY,
  parameter int SAMPLE_WIDTH = ucf_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_in,
  input  logic                                in_block_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample_out,
  output logic                                out_clipped,
  output logic                                out_block_end,
  input  logic                                cfg_wr_en,
  input  logic [ucf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ucf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ucf_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int PW  = $clog2(MAX_DELAY + 1) + 1;
  localparam int CW  = (PW > DELAY_W + 1) ? PW : DELAY_W + 1;
  localparam int PRW = GAIN_W + SW;
  localparam int ACW = PRW + 2;
  localparam int RW  = ACW - GAIN_FRAC;

  localparam logic signed [ACW-1:0] RND    = ACW'(1) << (GAIN_FRAC - 1);
  localparam logic signed [RW-1:0]  SMAX_R = (RW'(1) << (SW - 1)) - RW'(1);
  localparam logic signed [RW-1:0]  SMIN_R = ~SMAX_R;
  localparam logic signed [SW-1:0]  SMAX_S = SMAX_R[SW-1:0];
  localparam logic signed [SW-1:0]  SMIN_S = ~SMAX_S;
  localparam logic [AW-1:0]         WP_LAST = AW'(MAX_DELAY - 1);

  // configuration
  logic signed [GAIN_W-1:0] fir_gain_r, iir_gain_r;
  logic [DELAY_W-1:0]       delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fir_gain_r <= '0;
      iir_gain_r <= '0;
      delay_r    <= DELAY_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FIR_GAIN:     fir_gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_IIR_GAIN:     iir_gain_r <= cfg_wdata[GAIN_W-1:0];
        CFG_DELAY_LENGTH: delay_r    <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic in_fire, s1_adv, s2_adv;
  logic s1_v_r, s2_v_r, out_v_r;

  assign s2_adv   = s2_v_r && (!out_v_r || out_ready);
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_ready = !s1_v_r && (!s2_v_r || s2_adv);
  assign in_fire  = in_valid && in_ready;

  // write pointer and fill tracking
  logic [AW-1:0] wp_r;
  logic          wrapped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else if (in_fire) begin
      if (wp_r == WP_LAST) begin
        wp_r      <= '0;
        wrapped_r <= 1'b1;
      end else begin
        wp_r <= wp_r + AW'(1);
      end
    end
  end

  // read address: wp - D modulo the depth
  logic [CW-1:0] dly_ext, dly_eff, rd_sum, rd_wrap;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;

  always_comb begin
    dly_ext = CW'(delay_r);
    if (dly_ext == '0)
      dly_eff = CW'(1);
    else if (dly_ext > CW'(MAX_DELAY))
      dly_eff = CW'(MAX_DELAY);
    else
      dly_eff = dly_ext;
    rd_sum = CW'(wp_r) + CW'(MAX_DELAY) - dly_eff;
    if (rd_sum >= CW'(MAX_DELAY))
      rd_wrap = rd_sum - CW'(MAX_DELAY);
    else
      rd_wrap = rd_sum;
    rd_addr = rd_wrap[AW-1:0];
    rd_ok   = wrapped_r || (rd_addr < wp_r);
  end

  // history memory
  logic                 wr_en;
  logic [AW-1:0]        s2_wp_r;
  logic signed [SW-1:0] s2_x_r, y_sat;
  logic [SW-1:0]        mem_rx, mem_ry;

  assign wr_en = s2_adv;

  ucf_hist_mem #(
    .DEPTH (MAX_DELAY),
    .AW    (AW),
    .DW    (SW)
  ) u_hist (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (s2_wp_r),
    .wr_x    (s2_x_r),
    .wr_y    (y_sat),
    .rd_x    (mem_rx),
    .rd_y    (mem_ry)
  );

  // bypass of the write that lands on the edge the next item reads
  logic                 byp_v_r;
  logic [AW-1:0]        byp_addr_r;
  logic signed [SW-1:0] byp_x_r, byp_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
    end else if (wr_en) begin
      byp_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byp_addr_r <= s2_wp_r;
      byp_x_r    <= s2_x_r;
      byp_y_r    <= y_sat;
    end
  end

  // stage 1: delayed samples available, multiply
  logic signed [SW-1:0] s1_x_r;
  logic                 s1_be_r, s1_ok_r;
  logic [AW-1:0]        s1_wp_r, s1_rd_r;
  logic                 byp_hit;
  logic signed [SW-1:0] hx, hy;
  logic signed [PRW-1:0] pa_nxt, pb_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r  <= in_sample_in;
      s1_be_r <= in_block_end;
      s1_wp_r <= wp_r;
      s1_rd_r <= rd_addr;
      s1_ok_r <= rd_ok;
    end
  end

  always_comb begin
    byp_hit = byp_v_r && (byp_addr_r == s1_rd_r);
    if (byp_hit) begin
      hx = byp_x_r;
      hy = byp_y_r;
    end else if (s1_ok_r) begin
      hx = mem_rx;
      hy = mem_ry;
    end else begin
      hx = '0;
      hy = '0;
    end
    pa_nxt = PRW'(fir_gain_r) * PRW'(hx);
    pb_nxt = PRW'(iir_gain_r) * PRW'(hy);
  end

  // stage 2: sum, round, saturate, write back
  logic                  s2_be_r;
  logic signed [PRW-1:0] s2_pa_r, s2_pb_r;
  logic signed [ACW-1:0] acc;
  logic signed [RW-1:0]  rnd;
  logic                  clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_adv) begin
      s2_v_r <= 1'b1;
    end else if (s2_adv) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_x_r  <= s1_x_r;
      s2_be_r <= s1_be_r;
      s2_wp_r <= s1_wp_r;
      s2_pa_r <= pa_nxt;
      s2_pb_r <= pb_nxt;
    end
  end

  always_comb begin
    acc = (ACW'(s2_x_r) <<< GAIN_FRAC) + ACW'(s2_pa_r) + ACW'(s2_pb_r) + RND;
    rnd = acc[ACW-1:GAIN_FRAC];   // floor after adding half
    if (rnd > SMAX_R) begin
      y_sat = SMAX_S;
      clip  = 1'b1;
    end else if (rnd < SMIN_R) begin
      y_sat = SMIN_S;
      clip  = 1'b1;
    end else begin
      y_sat = rnd[SW-1:0];
      clip  = 1'b0;
    end
  end

  // output register
  logic signed [SW-1:0] out_sample_r;
  logic                 out_clip_r, out_be_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s2_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_sample_r <= y_sat;
      out_clip_r   <= clip;
      out_be_r     <= s2_be_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;
  assign out_block_end  = out_be_r;

  // checks
  a_s1_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_v_r && (s1_wp_r == $past(wp_r)))
    else $error("stage 1 not loaded with the accepted item");

  a_s1_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> !s1_v_r)
    else $error("stage 1 held an item, bypass would go stale");

  a_byp_track: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> byp_v_r && (byp_addr_r == $past(s2_wp_r)))
    else $error("bypass register missed a write-back");

  a_clip_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> (out_sample_out == SMAX_S) || (out_sample_out == SMIN_S))
    else $error("clipped item not at a range limit");

endmodule

### dv/tb_universal_comb_filter.sv
// Self-checking testbench for universal_comb_filter: directed and random items with a
// bit-exact predictor of the comb filter y = sat(round(x + a*x[n-D] + b*y[n-D])).
// Depends on ucf_pkg and the design sources only.
module tb_universal_comb_filter;
  import ucf_pkg::*;

  localparam int DEPTH          = DEF_MAX_DELAY;
  localparam int HAW            = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW             = DEF_SAMPLE_WIDTH;
  localparam int PIPE_LATENCY   = 3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint SMAX       = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SMIN       = -SMAX - 1;
  // index past the register list, must be ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 clipped;
    logic                 block_end;
  } comb_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SW-1:0]       in_sample_in;
  logic                       in_block_end;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SW-1:0]       out_sample_out;
  logic                       out_clipped;
  logic                       out_block_end;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;

  // filter model state
  logic signed [GAIN_W-1:0]   fir_gain_m;
  logic signed [GAIN_W-1:0]   iir_gain_m;
  logic [DELAY_W-1:0]         delay_m;
  logic signed [SW-1:0]       x_hist [DEPTH];
  logic signed [SW-1:0]       y_hist [DEPTH];
  int unsigned                wr_pos;
  comb_result_t               pending_q [$];
  comb_result_t               head;

  int  err_count       = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  clip_count      = 0;
  int  settings_used   = 0;
  int  stall_cycles    = 0;
  int  ready_hold;
  bit  idle_en         = 1'b0;

  always #2 clk = ~clk;

  universal_comb_filter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .in_block_end   (in_block_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_clipped    (out_clipped),
    .out_block_end  (out_block_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  function automatic void clear_filter_model();
    fir_gain_m = '0;
    iir_gain_m = '0;
    delay_m    = DELAY_W'(1);
    x_hist     = '{default: '0};
    y_hist     = '{default: '0};
    wr_pos     = 0;
  endfunction

  function automatic void model_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FIR_GAIN:     fir_gain_m = data;
      CFG_IIR_GAIN:     iir_gain_m = data;
      CFG_DELAY_LENGTH: delay_m    = data[DELAY_W-1:0];
      default: ;
    endcase
  endfunction

  // Works out the result of one accepted sample and advances the delay lines.
  function automatic void predict_comb(input logic signed [SW-1:0] x, input logic bend);
    int unsigned  d;
    int unsigned  rd;
    longint       acc;
    longint       y;
    comb_result_t r;
    d = 32'(delay_m);
    if (d == 0) d = 1;
    if (d > DEPTH) d = DEPTH;
    rd  = (wr_pos + DEPTH - d) % DEPTH;
    acc = (longint'(x) <<< GAIN_FRAC)
        + longint'(fir_gain_m) * longint'(x_hist[rd[HAW-1:0]])
        + longint'(iir_gain_m) * longint'(y_hist[rd[HAW-1:0]]);
    // add a half, then floor: halves go towards plus infinity
    y = (acc + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    r.clipped = 1'b0;
    if (y > SMAX) begin
      y = SMAX;
      r.clipped = 1'b1;
    end
    if (y < SMIN) begin
      y = SMIN;
      r.clipped = 1'b1;
    end
    r.sample    = SW'(y);
    r.block_end = bend;
    x_hist[wr_pos[HAW-1:0]] = x;
    y_hist[wr_pos[HAW-1:0]] = r.sample;
    wr_pos = (wr_pos + 1) % DEPTH;
    pending_q.push_back(r);
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(SW-1){1'b1}}};
      1:       return {1'b1, {(SW-1){1'b0}}};
      2:       return SW'(int'($urandom_range(0, 128)) - 64);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'(DEPTH);
      3:       return 16'($urandom_range(DEPTH + 1, 8191));
      4:       return 16'($urandom);    // bits above the register width dropped
      5, 6:    return 16'($urandom_range(17, 400));
      default: return 16'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    model_reg_write(idx, data);
  endtask

  // Holds the sender off until every outstanding result has been checked.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] a, input logic [CFG_DATA_W-1:0] b,
                               input logic [CFG_DATA_W-1:0] d_raw);
    drain_results();
    repeat (PIPE_LATENCY + 2) @(negedge clk);
    write_reg(CFG_FIR_GAIN, a);
    write_reg(CFG_IIR_GAIN, b);
    write_reg(CFG_DELAY_LENGTH, d_raw);
    if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 16'($urandom));
    settings_used++;
  endtask

  // Entered and left just after a falling edge; valid stays high on return.
  task automatic send_item(input logic signed [SW-1:0] x, input logic bend);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    in_block_end <= bend;
    do @(posedge clk); while (!in_ready);
    predict_comb(x, bend);
    items_sent++;
    @(negedge clk);
  endtask

  // Gains at zero after reset: output is the input, bit for bit.
  task automatic test_pass_through_at_reset();
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh0000, 1'b0);
    send_item(-16'sd1,   1'b1);
    send_item(16'sd1,    1'b0);
    send_item(16'sh5555, 1'b1);
  endtask

  task automatic test_saturation_and_rounding();
    // delay 0 behaves as 1
    apply_setting(16'h7FFF, 16'h0000, 16'd0);
    send_item(16'sh7FFF, 1'b0);
    send_item(16'sh7FFF, 1'b0);   // clips high
    send_item(16'sh8000, 1'b1);
    send_item(16'sh8000, 1'b0);   // clips low
    // gain of one lsb, delay 1 written with junk in the upper bits
    apply_setting(16'h0001, 16'h0000, 16'hE001);
    send_item(16'sd16384,  1'b0);
    send_item(16'sd5,      1'b0); // exact half: rounds up
    send_item(-16'sd16385, 1'b0);
    send_item(16'sd5,      1'b1); // just under minus half
    send_item(-16'sd16384, 1'b0);
    send_item(16'sd5,      1'b1); // minus half: rounds up to x
  endtask

  task automatic test_delay_limits();
    // delay above the memory depth clamps to the depth
    apply_setting(16'h8000, 16'h8000, 16'd8191);
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b1);
    send_item(16'sh1234, 1'b0);
    apply_setting(16'h8000, 16'h7FFF, 16'(DEPTH));
    send_item(16'sh8000, 1'b0);
    send_item(16'sh7FFF, 1'b1);
    // shorter delay reads the existing history straight away
    apply_setting(16'h0000, 16'h7FFF, 16'd2);
    send_item(16'sh4000, 1'b0);
    send_item(16'sh4000, 1'b0);
    send_item(16'sh4000, 1'b0);
    send_item(16'sh4000, 1'b1);
  endtask

  task automatic test_random_settings();
    int   n_items;
    int   blk;
    logic bend;
    for (int ph = 0; ph < 12; ph++) begin
      idle_en = ($urandom_range(0, 4) != 0);
      apply_setting(pick_gain(), pick_gain(), pick_delay());
      n_items = $urandom_range(90, 160);
      blk     = $urandom_range(1, 32);
      for (int k = 0; k < n_items; k++) begin
        if (k == n_items / 2 && (ph == 0 || $urandom_range(0, 2) == 0))
          drain_results();
        // block markers on a regular grid, with the odd stray one
        bend = ((k % blk) == blk - 1) ^ ($urandom_range(0, 19) == 0);
        send_item(pick_sample(), bend);
      end
    end
  endtask

  // No idling on either side from here on.
  task automatic test_full_rate();
    idle_en = 1'b0;
    apply_setting(16'h8000, 16'h7FFF, 16'd3);
    for (int k = 0; k < 100; k++) send_item(pick_sample(), 1'($urandom));
    apply_setting(16'h7FFF, 16'h8000, 16'd1);
    for (int k = 0; k < 100; k++) send_item(pick_sample(), 1'($urandom));
  endtask

  initial begin
    out_ready  = 1'b0;
    ready_hold = 0;
    forever begin
      @(negedge clk);
      if (idle_en && ready_hold == 0 && $urandom_range(0, 6) == 0)
        ready_hold = $urandom_range(1, 6);
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: sample %0d",
                                  out_sample_out));
      end else begin
        head = pending_q.pop_front();
        if (out_sample_out !== head.sample)
          report_mismatch($sformatf("result %0d sample_out %0d, want %0d",
                                    results_checked, out_sample_out, head.sample));
        if (out_clipped !== head.clipped)
          report_mismatch($sformatf("result %0d clipped %b, want %b",
                                    results_checked, out_clipped, head.clipped));
        if (out_block_end !== head.block_end)
          report_mismatch($sformatf("result %0d block_end %b, want %b",
                                    results_checked, out_block_end, head.block_end));
        if (head.clipped) clip_count++;
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    in_block_end = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    clear_filter_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_en = 1'b1;
    test_pass_through_at_reset();
    test_saturation_and_rounding();
    test_delay_limits();
    test_random_settings();
    test_full_rate();

    drain_results();
    repeat (PIPE_LATENCY + 5) @(negedge clk);
    $display("Summary: %0d samples over %0d gain/delay settings, %0d results compared",
             items_sent, settings_used, results_checked);
    $display("         %0d saturated results, %0d mismatches", clip_count, err_count);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
